FILE: rtl/wavetable_sine_oscillator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable sine oscillator
// Shorthands for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_SINE_OSCILLATOR_UNIT_ASSERT_SVH
`define WAVETABLE_SINE_OSCILLATOR_UNIT_ASSERT_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define WSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define WSO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wso_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable sine oscillator package
// Field widths, register codes, state types and the sine table generator.
// ----------------------------------------------------------------------------
package wso_pkg;

  localparam int FREQ_W      = 26;
  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 18;
  localparam int VSIZE_W     = 7;
  localparam int PHASE_FRAC  = 22;
  localparam int STEP_SHIFT  = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = RATE_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_VECTOR  = 64;

  localparam logic [RATE_W-1:0]  RESET_SAMPLE_RATE = RATE_W'(48000);
  localparam logic [VSIZE_W-1:0] RESET_VECTOR_SIZE = VSIZE_W'(64);

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_SIZE = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DIVIDE,
    FRONT_PUSH
  } front_state_t;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] Q30_HALF   = 64'd536870912;

  // term * x^2 in Q30.
  function automatic logic [63:0] mul_x2(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    return (t * x) >> 30;
  endfunction

  // First quadrant of the sine in Q1.15 from an eight term Taylor series in Q30.
  function automatic logic [15:0] quarter_sine(input int unsigned j, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (64'(j) * TWO_PI_Q30) >> tbits;
    term = x;
    sum  = x;
    term = mul_x2(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = mul_x2(term, x) / 64'd20;
    sum  = sum + term;
    term = mul_x2(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = mul_x2(term, x) / 64'd72;
    sum  = sum + term;
    term = mul_x2(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = mul_x2(term, x) / 64'd156;
    sum  = sum + term;
    term = mul_x2(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    r = (sum * 64'd32767 + Q30_HALF) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Full cycle entry built by mirroring the first quadrant.
  function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                    input int unsigned tbits);
    int unsigned q;
    logic [15:0] v;
    q = (32'd1 << tbits) >> 2;
    if (i <= q) begin
      v = quarter_sine(i, tbits);
      return $signed(v);
    end else if (i <= 2 * q) begin
      v = quarter_sine(2 * q - i, tbits);
      return $signed(v);
    end else if (i <= 3 * q) begin
      v = quarter_sine(i - 2 * q, tbits);
      return -$signed(v);
    end else begin
      v = quarter_sine(4 * q - i, tbits);
      return -$signed(v);
    end
  endfunction

endpackage

FILE: rtl/wso_sine_rom.sv
// ----------------------------------------------------------------------------
// Sine ROM
// One full sine cycle in Q1.15 with two registered read ports.
// ----------------------------------------------------------------------------
module wso_sine_rom #(
  parameter int TABLE_DEPTH = wso_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       addr_a,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       addr_b,
  output logic signed [wso_pkg::SAMPLE_W-1:0]  data_a,
  output logic signed [wso_pkg::SAMPLE_W-1:0]  data_b
);

  localparam int TBITS = $clog2(TABLE_DEPTH);

  logic signed [wso_pkg::SAMPLE_W-1:0] rom [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
    localparam logic signed [wso_pkg::SAMPLE_W-1:0] ENTRY = wso_pkg::sine_entry(g, TBITS);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

FILE: rtl/wso_front.sv
// ----------------------------------------------------------------------------
// Oscillator front end
// Holds the configuration, takes frequency items and derives the phase step
// with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module wso_front #(
  parameter int TABLE_DEPTH = wso_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_VECTOR  = wso_pkg::DEF_MAX_VECTOR
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  item_valid,
  output logic                                                  item_stall,
  input  logic signed [wso_pkg::FREQ_W-1:0]                     freq,
  input  logic                                                  cfg_valid,
  output logic                                                  cfg_ready,
  input  logic [wso_pkg::CFG_INDEX_W-1:0]                       cfg_index,
  input  logic [wso_pkg::CFG_DATA_W-1:0]                        cfg_data,
  output logic                                                  push_valid,
  input  logic                                                  push_ready,
  output logic [$clog2(TABLE_DEPTH)+wso_pkg::PHASE_FRAC-1:0]    push_step,
  output logic [$clog2(MAX_VECTOR+1)-1:0]                       push_count
);

  localparam int TBITS   = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = TBITS + wso_pkg::PHASE_FRAC;
  localparam int SHIFT   = TBITS + wso_pkg::STEP_SHIFT;
  localparam int DIV_W   = wso_pkg::FREQ_W + SHIFT;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int CNT_W   = $clog2(MAX_VECTOR + 1);
  localparam int RATE_W  = wso_pkg::RATE_W;

  wso_pkg::front_state_t state, state_next;

  logic [RATE_W-1:0]            sample_rate;
  logic [wso_pkg::VSIZE_W-1:0]  vector_size;
  logic [DIV_W-1:0]             div_reg, div_reg_next;
  logic [RATE_W-1:0]            rem, rem_next;
  logic [DCNT_W-1:0]            div_cnt;
  logic                         neg;
  logic [CNT_W-1:0]             count, count_sat;
  logic [wso_pkg::FREQ_W-1:0]   mag;
  logic [RATE_W:0]              trial, diff;
  logic                         fits;
  logic                         accept;
  logic [PHASE_W-1:0]           quot;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;

  assign mag = freq[wso_pkg::FREQ_W-1] ? (~unsigned'(freq) + 1'b1) : unsigned'(freq);
  assign count_sat = (vector_size > wso_pkg::VSIZE_W'(MAX_VECTOR)) ? CNT_W'(MAX_VECTOR)
                                                                  : CNT_W'(vector_size);

  // One quotient bit per cycle; the remainder stays below the divisor.
  assign trial        = {rem, div_reg[DIV_W-1]};
  assign fits         = trial >= {1'b0, sample_rate};
  assign diff         = trial - {1'b0, sample_rate};
  assign rem_next     = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
  assign div_reg_next = {div_reg[DIV_W-2:0], fits};

  // Only the quotient modulo the table span matters.
  assign quot       = div_reg[PHASE_W-1:0];
  assign push_step  = neg ? (PHASE_W'(0) - quot) : quot;
  assign push_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= wso_pkg::RESET_SAMPLE_RATE;
      vector_size <= wso_pkg::RESET_VECTOR_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wso_pkg::REG_SAMPLE_RATE: sample_rate <= cfg_data[RATE_W-1:0];
        wso_pkg::REG_VECTOR_SIZE: vector_size <= cfg_data[wso_pkg::VSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wso_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg     <= freq[wso_pkg::FREQ_W-1];
      count   <= count_sat;
      rem     <= '0;
      div_cnt <= DCNT_W'(DIV_W);
      div_reg <= (sample_rate == '0) ? '0 : {mag, {SHIFT{1'b0}}};
    end else if (state == wso_pkg::FRONT_DIVIDE) begin
      rem     <= rem_next;
      div_reg <= div_reg_next;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    push_valid = 1'b0;
    unique case (state)
      wso_pkg::FRONT_IDLE: begin
        item_stall = 1'b0;
        if (accept) begin
          // An empty vector leaves nothing for the back end to do.
          if (count_sat == '0) begin
            state_next = wso_pkg::FRONT_IDLE;
          end else if (sample_rate == '0) begin
            state_next = wso_pkg::FRONT_PUSH;
          end else begin
            state_next = wso_pkg::FRONT_DIVIDE;
          end
        end
      end
      wso_pkg::FRONT_DIVIDE: begin
        if (div_cnt == DCNT_W'(1)) begin
          state_next = wso_pkg::FRONT_PUSH;
        end
      end
      wso_pkg::FRONT_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = wso_pkg::FRONT_IDLE;
        end
      end
      default: state_next = wso_pkg::FRONT_IDLE;
    endcase
  end

endmodule

FILE: rtl/wso_queue.sv
// ----------------------------------------------------------------------------
// Step queue
// Small FIFO carrying phase step and sample count from front to back.
// ----------------------------------------------------------------------------
module wso_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wso_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             push, pop;

  assign push_ready = level != LVL_W'(DEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/wso_back.sv
// ----------------------------------------------------------------------------
// Oscillator back end
// Steps the phase once per sample, reads the sine ROM at two neighboring
// entries and interpolates linearly in a short stalling pipeline.
// ----------------------------------------------------------------------------
module wso_back #(
  parameter int TABLE_DEPTH = wso_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_VECTOR  = wso_pkg::DEF_MAX_VECTOR
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                pop_valid,
  output logic                                                pop_ready,
  input  logic [$clog2(TABLE_DEPTH)+wso_pkg::PHASE_FRAC-1:0]  pop_step,
  input  logic [$clog2(MAX_VECTOR+1)-1:0]                     pop_count,
  output logic                                                result_valid,
  input  logic                                                result_stall,
  output logic signed [wso_pkg::SAMPLE_W-1:0]                 sample,
  output logic                                                last
);

  localparam int TBITS   = $clog2(TABLE_DEPTH);
  localparam int FRAC    = wso_pkg::PHASE_FRAC;
  localparam int PHASE_W = TBITS + FRAC;
  localparam int CNT_W   = $clog2(MAX_VECTOR + 1);
  localparam int SW      = wso_pkg::SAMPLE_W;
  localparam int DIFF_W  = SW + 1;
  localparam int PROD_W  = DIFF_W + FRAC + 1;

  logic [PHASE_W-1:0]        phase, cur_step;
  logic [CNT_W-1:0]          remaining;
  logic                      advance, issue;
  logic [TBITS-1:0]          idx, nxt;

  logic                      s1_valid, s1_last;
  logic [FRAC-1:0]           s1_frac;
  logic signed [SW-1:0]      ta, tb;

  logic                      s2_valid, s2_last;
  logic signed [SW-1:0]      s2_base;
  logic signed [PROD_W-1:0]  s2_prod;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  rounded;

  // The whole pipeline holds while a finished sample waits at the output.
  assign advance   = !result_valid || !result_stall;
  assign pop_ready = advance && (remaining == '0);
  assign issue     = advance && (remaining != '0);

  assign idx = phase[PHASE_W-1:FRAC];
  assign nxt = idx + 1'b1;

  wso_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .en     (advance),
    .addr_a (idx),
    .addr_b (nxt),
    .data_a (ta),
    .data_b (tb)
  );

  assign diff    = {tb[SW-1], tb} - {ta[SW-1], ta};
  assign rounded = s2_prod + PROD_W'(1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      remaining <= '0;
    end else if (pop_valid && pop_ready) begin
      remaining <= pop_count;
    end else if (issue) begin
      phase     <= phase + cur_step;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_step <= pop_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= issue;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_frac <= phase[FRAC-1:0];
      s1_last <= (remaining == CNT_W'(1));
      s2_base <= ta;
      s2_last <= s1_last;
      s2_prod <= diff * $signed({1'b0, s1_frac});
      // The interpolated value always lies between the two entries.
      sample  <= s2_base + SW'(rounded >>> FRAC);
      last    <= s2_last;
    end
  end

endmodule

FILE: rtl/wavetable_sine_oscillator_unit.sv
// ----------------------------------------------------------------------------
// Wavetable sine oscillator
// Turns each frequency item into a vector of linearly interpolated sine
// samples read from a quarter-wave derived Q1.15 table.
//
//   channel  handshake                payload
//   item     item_valid / item_stall  freq
//   result   result_valid / result_stall  sample, last
//   cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The front accepts an item, derives its phase step in the bit-serial divider and then
// hands the step over to the step queue. The back end loads the step and sample count,
// then produces one sample per cycle while result_stall is low; each sample passes the
// ROM read register, the product register and the output register after its phase step.
// Reset loads sample_rate 48000, vector_size 64 and a zero phase; the ROM needs no fill.
// A stalled result freezes the back pipeline while the two entry step queue lets the front divide.
// ----------------------------------------------------------------------------
`include "wavetable_sine_oscillator_unit_assert.svh"

module wavetable_sine_oscillator_unit #(
  parameter int TABLE_DEPTH = wso_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_VECTOR  = wso_pkg::DEF_MAX_VECTOR
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic signed [wso_pkg::FREQ_W-1:0]    freq,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [wso_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wso_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wso_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PHASE_W = $clog2(TABLE_DEPTH) + wso_pkg::PHASE_FRAC;
  localparam int CNT_W   = $clog2(MAX_VECTOR + 1);
  localparam int ENTRY_W = PHASE_W + CNT_W;
  localparam int QDEPTH  = wso_pkg::QUEUE_DEPTH;
  localparam int LVL_W   = $clog2(QDEPTH + 1);

  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [PHASE_W-1:0] push_step, pop_step;
  logic [CNT_W-1:0]   push_count, pop_count;
  logic [LVL_W-1:0]   q_level;

  wso_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_VECTOR  (MAX_VECTOR)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .freq       (freq),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_step  (push_step),
    .push_count (push_count)
  );

  wso_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_step, push_count}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   ({pop_step, pop_count}),
    .level      (q_level)
  );

  wso_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_VECTOR  (MAX_VECTOR)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_step     (pop_step),
    .pop_count    (pop_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .last         (last)
  );

  `WSO_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")
  `WSO_ASSERT(a_queue_level, q_level <= LVL_W'(QDEPTH), "step queue level out of range")

endmodule
